// ===== rtl/core/fbc_pkg.sv =====
// Types and constants for the frustum box classifier.
// No dependencies.
package fbc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int NUM_AXES   = 3;
    localparam int COORD_W    = 16;
    localparam int PLANE_W    = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = 32;
    localparam int OFF_SHIFT  = 14;
    localparam int OFF_W      = COORD_W + OFF_SHIFT;
    localparam int DIST_W     = 35;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DIST_W-1:0]  dist_t;
    typedef logic [PLANE_W-1:0]        plane_t;
    typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

    typedef enum logic [1:0] {
        CLASS_INSIDE       = 2'd0,
        CLASS_INTERSECTING = 2'd1,
        CLASS_OUTSIDE      = 2'd2
    } box_class_t;

    typedef struct packed {
        coord_t [NUM_AXES-1:0] lo;
        coord_t [NUM_AXES-1:0] hi;
    } box_t;

    typedef struct packed {
        logic en1;
        logic en2;
    } lane_ctl_t;

endpackage

// ===== rtl/core/fbc_box_if.sv =====
// Box input channel: valid/ready and six Q8.8 coordinates.
// Depends on fbc_pkg.
interface fbc_box_if
    import fbc_pkg::*;
;
    logic   valid;
    logic   ready;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;

    modport source (output valid, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, input ready);
    modport sink   (input valid, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, output ready);
endinterface

// ===== rtl/core/fbc_class_if.sv =====
// Classification result channel: valid/ready and a 2-bit class.
// Depends on nothing.
interface fbc_class_if;
    logic       valid;
    logic       ready;
    logic [1:0] box_class;

    modport source (output valid, box_class, input ready);
    modport sink   (input valid, box_class, output ready);
endinterface

// ===== rtl/core/fbc_cfg_if.sv =====
// Plane register write channel: valid/ready, register index, write data.
// Depends on fbc_pkg.
interface fbc_cfg_if
    import fbc_pkg::*;
;
    logic     valid;
    logic     ready;
    cfg_idx_t index;
    plane_t   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/fbc_plane_lane.sv =====
// One clip plane: corner select and products (stage 1), distance sums (stage 2).
// Depends on fbc_pkg.
module fbc_plane_lane
    import fbc_pkg::*;
(
    input  logic      clk,
    input  lane_ctl_t ctl,
    input  box_t      box,
    input  plane_t    plane,
    output dist_t     dnear,
    output dist_t     dfar
);

    prod_t [NUM_AXES-1:0]    prod_near_next;
    prod_t [NUM_AXES-1:0]    prod_far_next;
    prod_t [NUM_AXES-1:0]    prod_near_reg;
    prod_t [NUM_AXES-1:0]    prod_far_reg;
    logic signed [OFF_W-1:0] off_next;
    logic signed [OFF_W-1:0] off_reg;
    dist_t                   dnear_next;
    dist_t                   dfar_next;
    dist_t                   dnear_reg;
    dist_t                   dfar_reg;

    always_comb
    begin
        coord_t n;
        coord_t c_near;
        coord_t c_far;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            n = coord_t'(plane[COORD_W*a +: COORD_W]);
            if (n > coord_t'(0))
            begin
                c_near = coord_t'(box.lo[a]);
                c_far  = coord_t'(box.hi[a]);
            end
            else
            begin
                c_near = coord_t'(box.hi[a]);
                c_far  = coord_t'(box.lo[a]);
            end
            prod_near_next[a] = prod_t'(c_near) * prod_t'(n);
            prod_far_next[a]  = prod_t'(c_far) * prod_t'(n);
        end
        off_next = signed'({plane[PLANE_W-1 -: COORD_W], {OFF_SHIFT{1'b0}}});
    end

    always_comb
    begin
        dnear_next = DIST_W'(off_reg);
        dfar_next  = DIST_W'(off_reg);
        for (int a = 0; a < NUM_AXES; a++)
        begin
            dnear_next = dnear_next + DIST_W'(prod_near_reg[a]);
            dfar_next  = dfar_next + DIST_W'(prod_far_reg[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en1)
        begin
            prod_near_reg <= prod_near_next;
            prod_far_reg  <= prod_far_next;
            off_reg       <= off_next;
        end
        if (ctl.en2)
        begin
            dnear_reg <= dnear_next;
            dfar_reg  <= dfar_next;
        end
    end

    assign dnear = dnear_reg;
    assign dfar  = dfar_reg;

endmodule

// ===== rtl/core/frustum_box_classifier.sv =====
// Frustum box classifier top level: plane registers, six plane lanes, class stage.
// Depends on fbc_pkg, fbc_box_if, fbc_class_if, fbc_cfg_if, fbc_plane_lane.
// An accepted box passes the product, sum and class registers to reach the output.
// Throughput: one box per cycle if cls.ready; a stage holds only behind a held stage.
// Reset clears all pipeline valids and zeroes the planes, so boxes read intersecting.
// Configuration writes are always accepted.
module frustum_box_classifier
    import fbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fbc_box_if.sink     box,
    fbc_class_if.source cls,
    fbc_cfg_if.sink     cfg
);

    plane_t [NUM_PLANES-1:0] plane_reg;
    dist_t  [NUM_PLANES-1:0] dnear;
    dist_t  [NUM_PLANES-1:0] dfar;
    box_t                    box_in;
    lane_ctl_t               ctl;
    logic                    v1_reg;
    logic                    v2_reg;
    logic                    v3_reg;
    logic                    en3;
    box_class_t              class_next;
    box_class_t              class_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            plane_reg <= '0;
        else if (cfg.valid && (cfg.index < cfg_idx_t'(NUM_PLANES)))
            plane_reg[cfg.index] <= cfg.data;
    end

    assign en3     = !v3_reg || cls.ready;
    assign ctl.en2 = !v2_reg || en3;
    assign ctl.en1 = !v1_reg || ctl.en2;
    assign box.ready = ctl.en1;

    assign box_in.lo[0] = box.box_min_x;
    assign box_in.lo[1] = box.box_min_y;
    assign box_in.lo[2] = box.box_min_z;
    assign box_in.hi[0] = box.box_max_x;
    assign box_in.hi[1] = box.box_max_y;
    assign box_in.hi[2] = box.box_max_z;

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_lane
        fbc_plane_lane u_lane (
            .clk   (clk),
            .ctl   (ctl),
            .box   (box_in),
            .plane (plane_reg[p]),
            .dnear (dnear[p]),
            .dfar  (dfar[p])
        );
    end

    always_comb
    begin
        logic outside;
        logic isect;
        outside = 1'b0;
        isect   = 1'b0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            outside = outside | (dnear[p] > dist_t'(0));
            isect   = isect | (dfar[p] >= dist_t'(0));
        end
        priority if (outside)
            class_next = CLASS_OUTSIDE;
        else if (isect)
            class_next = CLASS_INTERSECTING;
        else
            class_next = CLASS_INSIDE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ctl.en1)
                v1_reg <= box.valid;
            if (ctl.en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
            class_reg <= class_next;
    end

    assign cls.valid     = v3_reg;
    assign cls.box_class = class_reg;

endmodule

// ===== sim/frustum_box_classifier_tb.sv =====
// Testbench for frustum_box_classifier: sends random and directed boxes under
// several plane settings and checks each class word against a local predictor.
// Depends on fbc_pkg, fbc_box_if, fbc_class_if, fbc_cfg_if and the block RTL.
module frustum_box_classifier_tb
    import fbc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int U           = 256;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_BOXES = 250;

    typedef enum {
        SET_ZERO,
        SET_ONES,
        SET_FIELD_MAX,
        SET_FIELD_MIN,
        SET_CUBE,
        SET_TILTED,
        SET_RANDOM,
        SET_EDGES
    } plane_set_t;

    class frustum_model;
        plane_t     planes[NUM_PLANES];
        box_class_t pending_classes[$];
        int         errors;
        int         boxes;
        int         settings;
        int         seen[3];

        function new();
            foreach (planes[i])
                planes[i] = '0;
            errors   = 0;
            boxes    = 0;
            settings = 0;
            foreach (seen[i])
                seen[i] = 0;
        endfunction

        function void load_plane(cfg_idx_t idx, plane_t val);
            if (idx < NUM_PLANES)
                planes[idx] = val;
        endfunction

        function box_class_t classify_box(box_t b);
            coord_t n;
            coord_t c_lo;
            coord_t c_hi;
            longint near_d;
            longint far_d;
            bit     outside;
            bit     touching;
            outside  = 0;
            touching = 0;
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                near_d = longint'(coord_t'(planes[p][63:48])) * 16384;
                far_d  = near_d;
                for (int a = 0; a < NUM_AXES; a++)
                begin
                    n    = coord_t'(planes[p][16*a +: 16]);
                    c_lo = b.lo[a];
                    c_hi = b.hi[a];
                    if (n > 0)
                    begin
                        near_d += longint'(c_lo) * longint'(n);
                        far_d  += longint'(c_hi) * longint'(n);
                    end
                    else
                    begin
                        near_d += longint'(c_hi) * longint'(n);
                        far_d  += longint'(c_lo) * longint'(n);
                    end
                end
                if (near_d > 0)
                    outside = 1;
                else if (far_d >= 0)
                    touching = 1;
            end
            if (outside)
                return CLASS_OUTSIDE;
            return touching ? CLASS_INTERSECTING : CLASS_INSIDE;
        endfunction

        function void note_box(box_t b);
            pending_classes.push_back(classify_box(b));
            boxes++;
        endfunction

        function void check_class(logic [1:0] got);
            box_class_t want;
            if (pending_classes.size() == 0)
            begin
                errors++;
                if (errors <= 50)
                    $display("%0t: class word %0d with no box waiting", $time, got);
                return;
            end
            want = pending_classes.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 50)
                    $display("%0t: box_class mismatch, expected %0d (%s) actual %0d",
                             $time, want, want.name(), got);
            end
            if (got < 3)
                seen[got]++;
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    fbc_box_if   box_ch ();
    fbc_class_if cls_ch ();
    fbc_cfg_if   cfg_ch ();

    frustum_box_classifier uut (
        .clk   (clk),
        .rst_n (rst_n),
        .box   (box_ch),
        .cls   (cls_ch),
        .cfg   (cfg_ch)
    );

    frustum_model sb;
    int           box_idle_pct   = 30;
    int           ready_idle_pct = 30;
    bit           hold_off_req   = 0;
    plane_set_t   phase_kinds[RAND_PHASES] = '{SET_CUBE, SET_TILTED, SET_RANDOM, SET_EDGES,
                                               SET_CUBE, SET_TILTED, SET_ONES, SET_CUBE};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        cls_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                cls_ch.ready <= 1'b0;
                hold_off_req = 0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
                cls_ch.ready <= ($urandom_range(99) >= ready_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cls_ch.valid && cls_ch.ready)
            sb.check_class(cls_ch.box_class);
    end

    function automatic coord_t clamp_q88(int v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return coord_t'(v);
    endfunction

    function automatic box_t mk_box(int x0, int y0, int z0, int x1, int y1, int z1);
        box_t b;
        b.lo[0] = coord_t'(x0);
        b.lo[1] = coord_t'(y0);
        b.lo[2] = coord_t'(z0);
        b.hi[0] = coord_t'(x1);
        b.hi[1] = coord_t'(y1);
        b.hi[2] = coord_t'(z1);
        return b;
    endfunction

    // mostly well-formed boxes around the origin; some corner values and raw noise
    function automatic box_t random_box(int span);
        box_t   b;
        int     pick;
        int     c;
        int     h;
        coord_t corner_vals[4];
        corner_vals = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                b.lo[a] = corner_vals[$urandom_range(3)];
                b.hi[a] = corner_vals[$urandom_range(3)];
            end
        end
        else if (pick < 25)
            b = {$urandom, $urandom, $urandom};
        else
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                c = int'($urandom_range(2 * span * U)) - span * U;
                h = ($urandom_range(9) == 0) ? int'($urandom_range(100 * U))
                                             : int'($urandom_range(15 * U));
                b.lo[a] = clamp_q88(c - h);
                b.hi[a] = clamp_q88(c + h);
            end
        end
        return b;
    endfunction

    function automatic plane_t pack_plane(int nx, int ny, int nz, int off);
        return {16'(off), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    task automatic write_reg(cfg_idx_t idx, plane_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.load_plane(idx, val);
        @(negedge clk);
    endtask

    task automatic load_planes(plane_set_t kind, int half, bit junk);
        plane_t          vals[NUM_PLANES];
        logic [15:0]     edge_vals[6];
        logic [3:0][15:0] f;
        edge_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000};
        for (int i = 0; i < NUM_PLANES; i++)
        begin
            case (kind)
                SET_ZERO:      vals[i] = '0;
                SET_ONES:      vals[i] = '1;
                SET_FIELD_MAX: vals[i] = {4{16'h7FFF}};
                SET_FIELD_MIN: vals[i] = {4{16'h8000}};
                SET_CUBE:
                begin
                    f = '0;
                    f[i / 2] = (i % 2 == 0) ? 16'hC000 : 16'h4000;
                    f[3] = 16'(-half);
                    vals[i] = f;
                end
                SET_TILTED:
                    vals[i] = pack_plane(int'($urandom_range(32768)) - 16384,
                                         int'($urandom_range(32768)) - 16384,
                                         int'($urandom_range(32768)) - 16384,
                                         -int'($urandom_range(80 * U, 20 * U)));
                SET_RANDOM:    vals[i] = {$urandom, $urandom};
                default:
                begin
                    for (int k = 0; k < 4; k++)
                        f[k] = edge_vals[$urandom_range(5)];
                    vals[i] = f;
                end
            endcase
        end
        for (int i = 0; i < NUM_PLANES; i++)
            write_reg(cfg_idx_t'(i), vals[i]);
        // indexes past the last plane must be dropped
        if (junk)
        begin
            write_reg(cfg_idx_t'(NUM_PLANES), {$urandom, $urandom});
            write_reg(cfg_idx_t'(NUM_PLANES + 1), {$urandom, $urandom});
        end
        cfg_ch.valid <= 1'b0;
        sb.settings++;
    endtask

    task automatic offer_box(box_t b);
        if ($urandom_range(99) < box_idle_pct)
        begin
            box_ch.valid <= 1'b0;
            @(negedge clk);
        end
        box_ch.valid     <= 1'b1;
        box_ch.box_min_x <= b.lo[0];
        box_ch.box_min_y <= b.lo[1];
        box_ch.box_min_z <= b.lo[2];
        box_ch.box_max_x <= b.hi[0];
        box_ch.box_max_y <= b.hi[1];
        box_ch.box_max_z <= b.hi[2];
        do
            @(posedge clk);
        while (!box_ch.ready);
        sb.note_box(b);
        @(negedge clk);
    endtask

    task automatic drain_results();
        box_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending_classes.size() != 0);
        repeat (5) @(negedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n            = 1'b0;
        box_ch.valid     = 1'b0;
        box_ch.box_min_x = '0;
        box_ch.box_min_y = '0;
        box_ch.box_min_z = '0;
        box_ch.box_max_x = '0;
        box_ch.box_max_y = '0;
        box_ch.box_max_z = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // planes at reset: every box touches
        offer_box(mk_box(0, 0, 0, 0, 0, 0));
        offer_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        offer_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768));
        drain_results();

        load_planes(SET_CUBE, 40 * U, 1);
        offer_box(mk_box(-5 * U, -5 * U, -5 * U, 5 * U, 5 * U, 5 * U));
        offer_box(mk_box(30 * U, -5 * U, -5 * U, 45 * U, 5 * U, 5 * U));
        offer_box(mk_box(-60 * U, -5 * U, -5 * U, -50 * U, 5 * U, 5 * U));
        offer_box(mk_box(50 * U, -5 * U, -5 * U, 60 * U, 5 * U, 5 * U));
        offer_box(mk_box(-5 * U, -60 * U, -5 * U, 5 * U, -50 * U, 5 * U));
        offer_box(mk_box(-5 * U, 50 * U, -5 * U, 5 * U, 60 * U, 5 * U));
        offer_box(mk_box(-5 * U, -5 * U, -60 * U, 5 * U, 5 * U, -50 * U));
        offer_box(mk_box(-5 * U, -5 * U, 50 * U, 5 * U, 5 * U, 60 * U));
        offer_box(mk_box(30 * U, -5 * U, -5 * U, 40 * U, 5 * U, 5 * U));
        offer_box(mk_box(40 * U, -5 * U, -5 * U, 50 * U, 5 * U, 5 * U));
        offer_box(mk_box(5 * U, 5 * U, 5 * U, -5 * U, -5 * U, -5 * U));
        offer_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        drain_results();

        load_planes(SET_FIELD_MAX, 0, 0);
        offer_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        offer_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        offer_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));
        drain_results();

        load_planes(SET_FIELD_MIN, 0, 0);
        offer_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        offer_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        offer_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768));

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain_results();
            box_idle_pct   = (ph == 4) ? 0 : 30;
            ready_idle_pct = box_idle_pct;
            load_planes(phase_kinds[ph], int'($urandom_range(80, 10)) * U,
                        bit'($urandom_range(1)));
            for (int i = 0; i < PHASE_BOXES; i++)
            begin
                if (ph == 4 && i == 20)
                    hold_off_req = 1;
                if (ph == 1 && i == PHASE_BOXES / 2)
                    drain_results();
                offer_box(random_box(60));
            end
        end

        drain_results();
        load_planes(SET_ZERO, 0, 0);
        for (int i = 0; i < 20; i++)
            offer_box(random_box(60));
        drain_results();
        repeat (8) @(posedge clk);

        $display("%0d boxes over %0d plane settings: %0d inside, %0d intersecting, %0d outside",
                 sb.boxes, sb.settings, sb.seen[0], sb.seen[1], sb.seen[2]);
        $display("random stalls both sides, one %0d-cycle output hold-off, one full drain pause",
                 HOLD_CYCLES);
        if (sb.errors == 0 && sb.pending_classes.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
